// ===== sv/modbus_rtu_read_request_and_check_core_macros.svh =====
// Assertion helpers shared by the receive checker and the core's top module.
`ifndef MODBUS_RTU_READ_REQUEST_AND_CHECK_CORE_MACROS_SVH
`define MODBUS_RTU_READ_REQUEST_AND_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRR_CHK_NOW(lbl, ck, rn, ant, con, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRR_CHK_NEXT(lbl, ck, rn, ant, con, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) else $error(msg);

`endif

// ===== sv/mrr_pkg.sv =====
package mrr_pkg;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    localparam logic [1:0] REG_SLAVE    = 2'd0;
    localparam logic [1:0] REG_KIND     = 2'd1;
    localparam logic [1:0] REG_START    = 2'd2;
    localparam logic [1:0] REG_QUANTITY = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [1:0]  read_kind;
        logic [15:0] start_address;
        logic [15:0] quantity;
    } cfg_t;

    // Modbus function code: coils 01, discrete 02, holding 03, input 04
    function automatic logic [7:0] fn_code(input logic [1:0] kind);
        return {6'b0, kind} + 8'd1;
    endfunction

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/mrr_req_ser.sv =====
module mrr_req_ser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               advance,
    input  mrr_pkg::cfg_t      cfg,
    output logic               busy,
    output logic [7:0]         byte_out,
    output logic               last_out
);
    import mrr_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic [47:0] frame_reg, frame_next;
    logic [15:0] crc_reg, crc_next;

    assign busy     = busy_reg;
    assign last_out = (idx_reg == 3'd7);

    always_comb
    begin
        case (idx_reg)
            3'd6:    byte_out = crc_reg[7:0];
            3'd7:    byte_out = crc_reg[15:8];
            default: byte_out = frame_reg[47:40];
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        frame_next = frame_reg;
        crc_next   = crc_reg;
        if (advance) begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg < 3'd6) begin
                crc_next   = crc16_byte(crc_reg, frame_reg[47:40]);
                frame_next = {frame_reg[39:0], 8'h00};
            end
            if (idx_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
        // load wins over the final byte so a new request follows at once
        if (load) begin
            busy_next  = 1'b1;
            idx_next   = 3'd0;
            crc_next   = CRC_INIT;
            frame_next = {cfg.slave_address, fn_code(cfg.read_kind),
                          cfg.start_address, cfg.quantity};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        crc_reg   <= crc_next;
    end

endmodule

// ===== sv/mrr_rx_check.sv =====
module mrr_rx_check #(
    parameter int MAX_FRAME = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_en,
    input  logic          clear,
    input  logic [7:0]    rx_byte,
    input  mrr_pkg::cfg_t cfg,
    output logic          ok
);
    import mrr_pkg::*;
    `include "modbus_rtu_read_request_and_check_core_macros.svh"

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int EXP_W = 18;

    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       bcnt_reg, bcnt_next;
    logic [EXP_W-1:0] expected;
    logic             full;

    assign full = (count_reg == CNT_W'(MAX_FRAME));

    always_comb
    begin
        if (cfg.read_kind[1]) begin
            expected = {1'b0, cfg.quantity, 1'b0};
        end else begin
            expected = EXP_W'((EXP_W'(cfg.quantity) + EXP_W'(7)) >> 3);
        end
        ok = (crc_reg == 16'h0000)
          && (func_reg == fn_code(cfg.read_kind))
          && (EXP_W'(bcnt_reg) == expected)
          && (EXP_W'(count_reg) == expected + EXP_W'(5))
          && !ovf_reg;
    end

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        func_next  = func_reg;
        bcnt_next  = bcnt_reg;
        if (clear) begin
            crc_next   = CRC_INIT;
            count_next = '0;
            ovf_next   = 1'b0;
            func_next  = 8'h00;
            bcnt_next  = 8'h00;
        end else if (byte_en) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                if (count_reg == CNT_W'(1)) func_next = rx_byte;
                if (count_reg == CNT_W'(2)) bcnt_next = rx_byte;
                crc_next   = crc16_byte(crc_reg, rx_byte);
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            func_reg  <= 8'h00;
            bcnt_reg  <= 8'h00;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            func_reg  <= func_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    `MRR_CHK_NOW(a_cnt_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_FRAME), "rx count past max frame")
    `MRR_CHK_NOW(a_ovf_full, clk, rst_n, ovf_reg, full, "overflow without full frame")

endmodule

// ===== sv/modbus_rtu_read_request_and_check_core.sv =====
// Modbus RTU read master. cmd 0 sends the 8-byte read request (address,
// function, start, quantity, CRC low byte first) as 8 output items, one per
// cycle while out_stall is low, last on the eighth; cmd 1 folds one response
// byte into the receive CRC and counters and gives no output; cmd 2 gives one
// verdict item (last=1) and, like cmd 0, restarts the receiver; cmd 3 is
// ignored. Input items are taken one per cycle through an input register
// while in_stall is low; a verdict waits until the request serializer is idle,
// and a request holds the serializer until its last byte leaves, when the next
// request can be loaded. Bytes beyond MAX_FRAME are dropped and force a failed
// verdict. Write the configuration registers only while the core is idle.
module modbus_rtu_read_request_and_check_core #(
    parameter int MAX_FRAME = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic        verdict_valid,
    output logic        answer_ok
);
    import mrr_pkg::*;
    `include "modbus_rtu_read_request_and_check_core_macros.svh"

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  rxb_reg;

    logic        out_valid_reg;
    logic        txv_reg;
    logic [7:0]  txb_reg;
    logic        last_reg;
    logic        vv_reg;
    logic        ok_reg;

    logic        out_free;
    logic        ser_busy, ser_adv, ser_last;
    logic [7:0]  ser_byte;
    logic        exec, send_exec, end_exec, rx_exec;
    logic        verdict_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign ser_adv  = ser_busy && out_free;

    always_comb
    begin
        case (cmd_reg)
            CMD_SEND: exec = !ser_busy || (ser_adv && ser_last);
            CMD_END:  exec = !ser_busy && out_free;
            default:  exec = 1'b1;
        endcase
    end

    assign send_exec = in_valid_reg && exec && (cmd_reg == CMD_SEND);
    assign end_exec  = in_valid_reg && exec && (cmd_reg == CMD_END);
    assign rx_exec   = in_valid_reg && (cmd_reg == CMD_RX);
    assign in_stall  = in_valid_reg && !exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.slave_address <= 8'd1;
            cfg_reg.read_kind     <= 2'd2;
            cfg_reg.start_address <= 16'd0;
            cfg_reg.quantity      <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SLAVE:    cfg_reg.slave_address <= cfg_data[7:0];
                REG_KIND:     cfg_reg.read_kind     <= cfg_data[1:0];
                REG_START:    cfg_reg.start_address <= cfg_data;
                REG_QUANTITY: cfg_reg.quantity      <= cfg_data;
                default:      cfg_reg.quantity      <= cfg_reg.quantity;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            cmd_reg <= cmd;
            rxb_reg <= rx_byte;
        end
    end

    mrr_req_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (send_exec),
        .advance  (ser_adv),
        .cfg      (cfg_reg),
        .busy     (ser_busy),
        .byte_out (ser_byte),
        .last_out (ser_last)
    );

    mrr_rx_check #(
        .MAX_FRAME (MAX_FRAME)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (rx_exec),
        .clear   (send_exec || end_exec),
        .rx_byte (rxb_reg),
        .cfg     (cfg_reg),
        .ok      (verdict_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (ser_adv || end_exec) begin
            out_valid_reg <= 1'b1;
        end else if (out_free) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_adv) begin
            txv_reg  <= 1'b1;
            txb_reg  <= ser_byte;
            last_reg <= ser_last;
            vv_reg   <= 1'b0;
            ok_reg   <= 1'b0;
        end else if (end_exec) begin
            txv_reg  <= 1'b0;
            txb_reg  <= 8'h00;
            last_reg <= 1'b1;
            vv_reg   <= 1'b1;
            ok_reg   <= verdict_ok;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = txv_reg;
    assign tx_byte       = txb_reg;
    assign last          = last_reg;
    assign verdict_valid = vv_reg;
    assign answer_ok     = ok_reg;

    `MRR_CHK_NOW(a_no_collide, clk, rst_n, ser_adv, !end_exec, "verdict collides with request byte")
    `MRR_CHK_NEXT(a_send_busy, clk, rst_n, send_exec, ser_busy, "serializer idle after send")
    `MRR_CHK_NOW(a_verdict_fmt, clk, rst_n, out_valid_reg && vv_reg, !txv_reg && last_reg, "bad verdict item")

endmodule
